### design/cdad_pkg.sv
`default_nettype none

package cdad_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned ADD_W   = 16;

    // Working day count: start day plus added days, with one spare bit for the carry.
    localparam int unsigned WDAY_W  = ADD_W + 1;
    localparam int unsigned ALU_W   = WDAY_W + 1;

    localparam logic [YEAR_W-1:0]  YEAR_MAX        = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_MAX         = DAY_W'(31);

    // Length of the full Gregorian leap cycle, and of the century inside it.
    localparam int unsigned        LEAP_W       = 9;
    localparam logic [LEAP_W-1:0]  LEAP_CYCLE   = LEAP_W'(400);
    localparam logic [LEAP_W-1:0]  CENTURY      = LEAP_W'(100);

    // Leap rule on the year's position inside the 400 year cycle.
    function automatic logic is_leap(input logic [LEAP_W-1:0] pos);
        logic on_century;
        on_century = (pos == CENTURY) || (pos == LEAP_W'(2 * 100)) ||
                     (pos == LEAP_W'(3 * 100));
        return (pos[1:0] == 2'b00) && !on_century;
    endfunction

    // Days in a month; the month is 1..12 wherever this is used.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
            4'd4:    len = DAY_W'(30);
            4'd6:    len = DAY_W'(30);
            4'd9:    len = DAY_W'(30);
            4'd11:   len = DAY_W'(30);
            default: len = DAY_W'(31);
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### design/calendar_date_add_days_unit.sv
`default_nettype none

// From start, LMOD reduces the year modulo 400 and STEP then crosses months until the
// day fits, before o_done; a bad word or a start year past the range answers from IDLE.
// Throughput: one word at a time; o_busy stays high until the result is strobed.
// The month stepping loop crosses one month per cycle.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and clears o_done.
// The receiver cannot stall: each result is valid for the single o_done cycle.
module calendar_date_add_days_unit
    import cdad_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [YEAR_W-1:0]  i_start_year,
    input  wire logic [MONTH_W-1:0] i_start_month,
    input  wire logic [DAY_W-1:0]   i_start_day,
    input  wire logic [ADD_W-1:0]   i_days_to_add,
    output logic                    o_done,
    output logic [YEAR_W-1:0]       o_result_year,
    output logic [MONTH_W-1:0]      o_result_month,
    output logic [DAY_W-1:0]        o_result_day,
    output logic                    o_year_overflow,
    output logic                    o_bad_input
);

    // Sequencer codes. IDLE takes a word; LMOD finds the year's place in the
    // 400 year leap cycle by repeated subtraction; STEP crosses one month per cycle.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LMOD = 2'd1;
    localparam logic [1:0] S_STEP = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [YEAR_W-1:0]  r_year,  n_year;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [WDAY_W-1:0]  r_day,   n_day;
    logic [YEAR_W-1:0]  r_mod,   n_mod;

    logic               r_done,  n_done;
    logic [YEAR_W-1:0]  r_res_year,  n_res_year;
    logic [MONTH_W-1:0] r_res_month, n_res_month;
    logic [DAY_W-1:0]   r_res_day,   n_res_day;
    logic               r_res_ovf,   n_res_ovf;
    logic               r_res_bad,   n_res_bad;

    // The one shared subtractor. In LMOD it reduces the year by 400; in STEP
    // it takes the current month's length off the day count. The top bit is
    // the borrow, so a clear top bit means the first operand was not smaller.
    logic [ALU_W-1:0]   alu_a, alu_b, alu_diff;
    logic               alu_borrow;
    logic [DAY_W-1:0]   cur_len;
    logic               leap;
    logic               bad;
    logic               fits;

    assign leap     = is_leap(r_mod[LEAP_W-1:0]);
    assign cur_len  = month_len(r_month, leap);

    always_comb begin
        if (r_state == S_LMOD) begin
            alu_a = ALU_W'(r_mod);
            alu_b = ALU_W'(LEAP_CYCLE);
        end else begin
            alu_a = ALU_W'(r_day);
            alu_b = ALU_W'(cur_len);
        end
    end

    assign alu_diff   = alu_a - alu_b;
    assign alu_borrow = alu_diff[ALU_W-1];
    // The day fits in the month when subtracting its length borrows or leaves zero.
    assign fits       = alu_borrow || (alu_diff == '0);

    assign bad = (i_start_month == '0) || (i_start_month > MONTHS_PER_YEAR) ||
                 (i_start_day == '0);

    always_comb begin
        n_state     = r_state;
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_mod       = r_mod;
        n_done      = 1'b0;
        n_res_year  = r_res_year;
        n_res_month = r_res_month;
        n_res_day   = r_res_day;
        n_res_ovf   = r_res_ovf;
        n_res_bad   = r_res_bad;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_year  = i_start_year;
                    n_month = i_start_month;
                    n_day   = WDAY_W'(i_start_day) + WDAY_W'(i_days_to_add);
                    n_mod   = i_start_year;
                    if (bad) begin
                        // A bad month or a zero day answers with all result fields clear.
                        n_done      = 1'b1;
                        n_res_year  = '0;
                        n_res_month = '0;
                        n_res_day   = '0;
                        n_res_ovf   = 1'b0;
                        n_res_bad   = 1'b1;
                    end else if (i_start_year > YEAR_MAX) begin
                        // A start year past the range saturates at once.
                        n_done      = 1'b1;
                        n_res_year  = YEAR_MAX;
                        n_res_month = MONTHS_PER_YEAR;
                        n_res_day   = DAY_MAX;
                        n_res_ovf   = 1'b1;
                        n_res_bad   = 1'b0;
                    end else begin
                        n_state = S_LMOD;
                    end
                end
            end
            S_LMOD: begin
                if (!alu_borrow) begin
                    n_mod = alu_diff[YEAR_W-1:0];
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (fits) begin
                    n_state     = S_IDLE;
                    n_done      = 1'b1;
                    n_res_year  = r_year;
                    n_res_month = r_month;
                    n_res_day   = r_day[DAY_W-1:0];
                    n_res_ovf   = 1'b0;
                    n_res_bad   = 1'b0;
                end else begin
                    n_day = alu_diff[WDAY_W-1:0];
                    if (r_month == MONTHS_PER_YEAR) begin
                        n_month = MONTH_W'(1);
                        if (r_year == YEAR_MAX) begin
                            // Stepping past December of the last year saturates.
                            n_state     = S_IDLE;
                            n_done      = 1'b1;
                            n_res_year  = YEAR_MAX;
                            n_res_month = MONTHS_PER_YEAR;
                            n_res_day   = DAY_MAX;
                            n_res_ovf   = 1'b1;
                            n_res_bad   = 1'b0;
                        end else begin
                            n_year = r_year + YEAR_W'(1);
                            if (r_mod[LEAP_W-1:0] == LEAP_CYCLE - LEAP_W'(1)) begin
                                n_mod = '0;
                            end else begin
                                n_mod = r_mod + YEAR_W'(1);
                            end
                        end
                    end else begin
                        n_month = r_month + MONTH_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Working and result registers carry payload only and need no reset.
    always_ff @(posedge i_clk) begin
        r_year      <= n_year;
        r_month     <= n_month;
        r_day       <= n_day;
        r_mod       <= n_mod;
        r_res_year  <= n_res_year;
        r_res_month <= n_res_month;
        r_res_day   <= n_res_day;
        r_res_ovf   <= n_res_ovf;
        r_res_bad   <= n_res_bad;
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_result_year   = r_res_year;
    assign o_result_month  = r_res_month;
    assign o_result_day    = r_res_day;
    assign o_year_overflow = r_res_ovf;
    assign o_bad_input     = r_res_bad;

`ifndef NO_ASSERTIONS
    // A result is strobed only once the sequencer has returned to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobed while busy");

    // A good word with an in-range year starts the sequencer.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !bad && (i_start_year <= YEAR_MAX)) |=> o_busy)
        else $error("accepted word did not start the sequencer");

    // A bad word reports clear result fields and no overflow.
    a_bad_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_bad_input) |-> ((o_result_year == '0) && (o_result_month == '0) &&
                                     (o_result_day == '0) && !o_year_overflow))
        else $error("bad word left result fields set");

    // Overflow always saturates to the last day of the range.
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_year_overflow) |-> ((o_result_year == YEAR_MAX) &&
                                         (o_result_month == MONTHS_PER_YEAR) &&
                                         (o_result_day == DAY_MAX)))
        else $error("overflow result not saturated");

    // While stepping, the month and leap cycle position stay in range.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> ((r_month != '0) && (r_month <= MONTHS_PER_YEAR) &&
                                 (r_mod < YEAR_W'(LEAP_CYCLE))))
        else $error("stepping state out of range");
`endif

endmodule

`default_nettype wire
